[hdl/smi_pkg.sv]
`default_nettype none
package smi_pkg;

  // Fraction bits of the fixed-point position, size and step values
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned COORD_W  = 12;
  localparam int unsigned SIZE_W   = 10;
  localparam int unsigned DUR_W    = 16;
  localparam int unsigned FRAME_W  = 8;
  localparam int unsigned POS_W    = 28;
  localparam int unsigned SCALE_W  = 26;
  localparam int unsigned SSTEP_W  = 27;
  localparam int unsigned TICK_W   = DUR_W + 1;
  localparam int unsigned DIFF_W   = COORD_W + 1;
  localparam int unsigned SDIFF_W  = SIZE_W + 1;

  // Divider numerator: magnitude of a difference shifted up by the fraction
  localparam int unsigned NUM_W    = POS_W;
  localparam int unsigned DCNT_W   = $clog2(NUM_W + 1);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   num;
    logic [DUR_W-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [NUM_W-1:0]   quot;
  } div_rsp_t;

endpackage
`default_nettype wire

[hdl/smi_divider.sv]
`default_nettype none
module smi_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire smi_pkg::div_req_t req_i,
  output smi_pkg::div_rsp_t      rsp_o
);

  logic [smi_pkg::DCNT_W-1:0] cnt_q, cnt_d;
  logic [smi_pkg::NUM_W-1:0]  quo_q, quo_d;
  logic [smi_pkg::DUR_W-1:0]  rem_q, rem_d;
  logic [smi_pkg::DUR_W-1:0]  den_q, den_d;
  logic                       done_q, done_d;

  logic [smi_pkg::DUR_W:0]    trial;
  logic [smi_pkg::DUR_W+1:0]  diff;
  logic                       take;

  // One restoring step per cycle: bring down the next numerator bit
  assign trial = {rem_q, quo_q[smi_pkg::NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};
  assign take  = !diff[smi_pkg::DUR_W+1];

  always_comb begin
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    done_d = 1'b0;
    if (req_i.start) begin
      cnt_d = smi_pkg::DCNT_W'(smi_pkg::NUM_W);
      quo_d = req_i.num;
      rem_d = '0;
      den_d = req_i.den;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      quo_d = {quo_q[smi_pkg::NUM_W-2:0], take};
      rem_d = take ? diff[smi_pkg::DUR_W-1:0] : trial[smi_pkg::DUR_W-1:0];
      done_d = (cnt_q == smi_pkg::DCNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = (cnt_q != '0);
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule
`default_nettype wire

[hdl/sprite_motion_interpolator_core.sv]
`default_nettype none
// Sprite motion stepper, 12.16 fixed-point position, 10.16 size.
//
// Input channel (in_valid_i / in_ready_o) carries one beat per command.
// A load beat sets start position and size, clears the frame and computes
// the three per-tick steps with one shared restoring divider, one quotient
// bit per cycle, run three times in turn (x, y, scale).  A tick beat
// counts down the duration; while active it steps frames and accumulators.
// Every input beat gives exactly one output beat (out_valid_o/out_ready_i)
// with active flag, position, size and frame after that command.
//
// A tick beat goes from the idle state straight to the emit state; a load
// beat first runs the x, y and scale divides, or goes straight to emit for a
// zero duration.  in_ready_o is high only when the sequencer is idle, so a
// new beat is taken only after the last result enters the output register.
// The output register parts the two sides: a new beat is taken while the
// previous result still waits; the next result then holds in the emit
// state until the receiver takes the old one.
// Reset (rst_ni low, asynchronous) leaves the sprite inactive at the
// origin with size zero, frame zero and no pending output beat.
module sprite_motion_interpolator_core (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic                                  command_i,
  input  wire logic signed [smi_pkg::COORD_W-1:0]    start_x_i,
  input  wire logic signed [smi_pkg::COORD_W-1:0]    start_y_i,
  input  wire logic        [smi_pkg::SIZE_W-1:0]     start_scale_i,
  input  wire logic signed [smi_pkg::COORD_W-1:0]    end_x_i,
  input  wire logic signed [smi_pkg::COORD_W-1:0]    end_y_i,
  input  wire logic        [smi_pkg::SIZE_W-1:0]     end_scale_i,
  input  wire logic        [smi_pkg::DUR_W-1:0]      tick_count_i,
  input  wire logic        [smi_pkg::FRAME_W-1:0]    frames_in_loop_i,
  input  wire logic        [smi_pkg::FRAME_W-1:0]    ticks_per_frame_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic                                       active_o,
  output logic signed [smi_pkg::POS_W-1:0]           pos_x_o,
  output logic signed [smi_pkg::POS_W-1:0]           pos_y_o,
  output logic        [smi_pkg::SCALE_W-1:0]         cur_scale_o,
  output logic        [smi_pkg::FRAME_W-1:0]         frame_index_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_X,
    S_DIV_Y,
    S_DIV_S,
    S_EMIT
  } state_e;

  localparam int unsigned PW = smi_pkg::POS_W;
  localparam int unsigned SW = smi_pkg::SCALE_W;
  localparam int unsigned FW = smi_pkg::FRAME_W;

  state_e state_q;
  logic   start_q;

  logic [PW-1:0]                acc_x_q, acc_y_q, step_x_q, step_y_q;
  logic [SW-1:0]                acc_s_q;
  logic [smi_pkg::SSTEP_W-1:0]  step_s_q;
  logic signed [smi_pkg::TICK_W-1:0] ticks_left_q;
  logic [FW-1:0]                frame_now_q, frame_limit_q, delay_reload_q, delay_left_q;
  logic [smi_pkg::DUR_W-1:0]    dur_q;
  logic signed [smi_pkg::DIFF_W-1:0]  diff_x_q, diff_y_q;
  logic signed [smi_pkg::SDIFF_W-1:0] diff_s_q;

  logic                         out_valid_q;

  smi_pkg::div_req_t div_req;
  smi_pkg::div_rsp_t div_rsp;

  logic signed [smi_pkg::DIFF_W-1:0] diff_sel, mag_sel;
  logic                              neg_sel;
  logic [PW-1:0]                     quot_signed;

  logic signed [smi_pkg::TICK_W-1:0] ticks_dec;
  logic                              run;
  logic [FW-1:0]                     delay_dec, frame_inc;
  logic                              in_fire, emit_fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign emit_fire  = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  // Pick the difference that the divider is working on
  always_comb begin
    case (state_q)
      S_DIV_X: diff_sel = diff_x_q;
      S_DIV_Y: diff_sel = diff_y_q;
      S_DIV_S: diff_sel = smi_pkg::DIFF_W'(diff_s_q);
      default: diff_sel = '0;
    endcase
  end

  assign neg_sel = diff_sel[smi_pkg::DIFF_W-1];
  assign mag_sel = neg_sel ? -diff_sel : diff_sel;

  assign div_req.start = start_q;
  assign div_req.num   = {{(smi_pkg::NUM_W - smi_pkg::DIFF_W){1'b0}}, mag_sel}
                         << smi_pkg::FRAC_BITS;
  assign div_req.den   = dur_q;

  // Truncation toward zero: divide magnitudes, then restore the sign
  assign quot_signed = neg_sel ? -div_rsp.quot : div_rsp.quot;

  smi_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Tick: drop the remaining duration, saturating at minus one
  assign ticks_dec = ticks_left_q[smi_pkg::TICK_W-1] ? ticks_left_q : ticks_left_q - 1'b1;
  assign run       = !ticks_dec[smi_pkg::TICK_W-1];
  assign delay_dec = delay_left_q - 1'b1;
  assign frame_inc = frame_now_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      start_q        <= 1'b0;
      acc_x_q        <= '0;
      acc_y_q        <= '0;
      acc_s_q        <= '0;
      step_x_q       <= '0;
      step_y_q       <= '0;
      step_s_q       <= '0;
      ticks_left_q   <= '1;
      frame_now_q    <= '0;
      frame_limit_q  <= FW'(1);
      delay_reload_q <= FW'(1);
      delay_left_q   <= FW'(1);
      out_valid_q    <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (out_valid_q && out_ready_i && !emit_fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (command_i == smi_pkg::CMD_LOAD) begin
              ticks_left_q   <= $signed({1'b0, tick_count_i});
              frame_limit_q  <= frames_in_loop_i;
              delay_reload_q <= ticks_per_frame_i;
              delay_left_q   <= ticks_per_frame_i;
              frame_now_q    <= '0;
              acc_x_q <= {{(PW - smi_pkg::COORD_W){start_x_i[smi_pkg::COORD_W-1]}},
                          start_x_i} << smi_pkg::FRAC_BITS;
              acc_y_q <= {{(PW - smi_pkg::COORD_W){start_y_i[smi_pkg::COORD_W-1]}},
                          start_y_i} << smi_pkg::FRAC_BITS;
              acc_s_q <= {{(SW - smi_pkg::SIZE_W){1'b0}}, start_scale_i}
                         << smi_pkg::FRAC_BITS;
              step_x_q <= '0;
              step_y_q <= '0;
              step_s_q <= '0;
              if (tick_count_i == '0) begin
                state_q <= S_EMIT;
              end else begin
                state_q <= S_DIV_X;
                start_q <= 1'b1;
              end
            end else begin
              ticks_left_q <= ticks_dec;
              if (run) begin
                if (delay_dec == '0) begin
                  frame_now_q  <= (frame_inc == frame_limit_q) ? '0 : frame_inc;
                  delay_left_q <= delay_reload_q;
                end else begin
                  delay_left_q <= delay_dec;
                end
                acc_x_q <= acc_x_q + step_x_q;
                acc_y_q <= acc_y_q + step_y_q;
                acc_s_q <= acc_s_q + step_s_q[SW-1:0];
              end
              state_q <= S_EMIT;
            end
          end
        end
        S_DIV_X: begin
          if (div_rsp.done) begin
            step_x_q <= quot_signed;
            state_q  <= S_DIV_Y;
            start_q  <= 1'b1;
          end
        end
        S_DIV_Y: begin
          if (div_rsp.done) begin
            step_y_q <= quot_signed;
            state_q  <= S_DIV_S;
            start_q  <= 1'b1;
          end
        end
        S_DIV_S: begin
          if (div_rsp.done) begin
            step_s_q <= quot_signed[smi_pkg::SSTEP_W-1:0];
            state_q  <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Hold here until the output register is free
          if (emit_fire) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Latch the duration and differences of a load beat, and the outputs on emit
  always_ff @(posedge clk_i) begin
    if (in_fire && (command_i == smi_pkg::CMD_LOAD)) begin
      dur_q    <= tick_count_i;
      diff_x_q <= smi_pkg::DIFF_W'(end_x_i) - smi_pkg::DIFF_W'(start_x_i);
      diff_y_q <= smi_pkg::DIFF_W'(end_y_i) - smi_pkg::DIFF_W'(start_y_i);
      diff_s_q <= $signed({1'b0, end_scale_i}) - $signed({1'b0, start_scale_i});
    end
    if (emit_fire) begin
      active_o      <= !ticks_left_q[smi_pkg::TICK_W-1];
      pos_x_o       <= acc_x_q;
      pos_y_o       <= acc_y_q;
      cur_scale_o   <= acc_s_q;
      frame_index_o <= frame_now_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // The divider runs only while the sequencer waits on it
  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> (state_q == S_DIV_X || state_q == S_DIV_Y || state_q == S_DIV_S))
    else $error("divider busy outside a divide state");

  // A tick beat reaches the emit state on the next cycle
  a_tick_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && command_i == smi_pkg::CMD_TICK) |=> (state_q == S_EMIT))
    else $error("tick did not go straight to emit");

  // A result is loaded only into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && state_q == S_EMIT) |=> (state_q == S_EMIT))
    else $error("output beat overwritten while stalled");

  // A division issue always comes with a nonzero divisor
  a_div_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> (dur_q != '0))
    else $error("division started with zero duration");

endmodule
`default_nettype wire

[sim/testbench.sv]
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic                        cmd;
    logic [smi_pkg::COORD_W-1:0] sx;
    logic [smi_pkg::COORD_W-1:0] sy;
    logic [smi_pkg::SIZE_W-1:0]  ss;
    logic [smi_pkg::COORD_W-1:0] ex;
    logic [smi_pkg::COORD_W-1:0] ey;
    logic [smi_pkg::SIZE_W-1:0]  es;
    logic [smi_pkg::DUR_W-1:0]   dur;
    logic [smi_pkg::FRAME_W-1:0] frames;
    logic [smi_pkg::FRAME_W-1:0] tpf;
  } motion_cmd_t;

  typedef struct packed {
    logic                        active;
    logic [smi_pkg::POS_W-1:0]   pos_x;
    logic [smi_pkg::POS_W-1:0]   pos_y;
    logic [smi_pkg::SCALE_W-1:0] scale;
    logic [smi_pkg::FRAME_W-1:0] frame;
  } sprite_view_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic command_i;
  logic signed [smi_pkg::COORD_W-1:0] start_x_i, start_y_i, end_x_i, end_y_i;
  logic [smi_pkg::SIZE_W-1:0] start_scale_i, end_scale_i;
  logic [smi_pkg::DUR_W-1:0] tick_count_i;
  logic [smi_pkg::FRAME_W-1:0] frames_in_loop_i, ticks_per_frame_i;
  logic out_valid_o;
  logic out_ready_i;
  logic active_o;
  logic signed [smi_pkg::POS_W-1:0] pos_x_o, pos_y_o;
  logic [smi_pkg::SCALE_W-1:0] cur_scale_o;
  logic [smi_pkg::FRAME_W-1:0] frame_index_o;

  sprite_motion_interpolator_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .start_x_i        (start_x_i),
    .start_y_i        (start_y_i),
    .start_scale_i    (start_scale_i),
    .end_x_i          (end_x_i),
    .end_y_i          (end_y_i),
    .end_scale_i      (end_scale_i),
    .tick_count_i     (tick_count_i),
    .frames_in_loop_i (frames_in_loop_i),
    .ticks_per_frame_i(ticks_per_frame_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .active_o         (active_o),
    .pos_x_o          (pos_x_o),
    .pos_y_o          (pos_y_o),
    .cur_scale_o      (cur_scale_o),
    .frame_index_o    (frame_index_o)
  );

  // Sprite state as the block should hold it
  logic [smi_pkg::POS_W-1:0]   acc_x = '0, acc_y = '0, step_x = '0, step_y = '0;
  logic [smi_pkg::SCALE_W-1:0] acc_scale = '0;
  logic [smi_pkg::SSTEP_W-1:0] step_scale = '0;
  int                          ticks_left = -1;
  logic [smi_pkg::FRAME_W-1:0] frame_now = '0;
  logic [smi_pkg::FRAME_W-1:0] frame_limit = smi_pkg::FRAME_W'(1);
  logic [smi_pkg::FRAME_W-1:0] delay_reload = smi_pkg::FRAME_W'(1);
  logic [smi_pkg::FRAME_W-1:0] delay_left = smi_pkg::FRAME_W'(1);

  sprite_view_t expected_views[$];
  sprite_view_t want;
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  function automatic logic [smi_pkg::POS_W-1:0] step_per_tick(int diff, int unsigned dur);
    longint scaled;
    if (dur == 0) return '0;
    scaled = longint'(diff) * (longint'(1) << smi_pkg::FRAC_BITS);
    scaled = scaled / longint'(dur);
    return scaled[smi_pkg::POS_W-1:0];
  endfunction

  function automatic sprite_view_t advance_sprite(motion_cmd_t m);
    sprite_view_t v;
    longint unit_val;
    logic [smi_pkg::POS_W-1:0] wide_scale_step;
    unit_val = longint'(1) << smi_pkg::FRAC_BITS;
    if (m.cmd == smi_pkg::CMD_LOAD) begin
      ticks_left = int'(m.dur);
      frame_limit = m.frames;
      delay_reload = m.tpf;
      delay_left = m.tpf;
      frame_now = '0;
      acc_x = smi_pkg::POS_W'(longint'($signed(m.sx)) * unit_val);
      acc_y = smi_pkg::POS_W'(longint'($signed(m.sy)) * unit_val);
      acc_scale = smi_pkg::SCALE_W'(longint'(m.ss) * unit_val);
      step_x = step_per_tick(int'($signed(m.ex)) - int'($signed(m.sx)), 32'(m.dur));
      step_y = step_per_tick(int'($signed(m.ey)) - int'($signed(m.sy)), 32'(m.dur));
      wide_scale_step = step_per_tick(int'(m.es) - int'(m.ss), 32'(m.dur));
      step_scale = wide_scale_step[smi_pkg::SSTEP_W-1:0];
    end else begin
      if (ticks_left >= 0) ticks_left--;
      if (ticks_left >= 0) begin
        delay_left = delay_left - 1'b1;
        if (delay_left == 0) begin
          frame_now = frame_now + 1'b1;
          if (frame_now == frame_limit) frame_now = '0;
          delay_left = delay_reload;
        end
        acc_x = acc_x + step_x;
        acc_y = acc_y + step_y;
        acc_scale = acc_scale + step_scale[smi_pkg::SCALE_W-1:0];
      end
    end
    v.active = (ticks_left >= 0);
    v.pos_x = acc_x;
    v.pos_y = acc_y;
    v.scale = acc_scale;
    v.frame = frame_now;
    return v;
  endfunction

  task automatic report_mismatch(string what, longint exp_val, longint got_val);
    $display("MISMATCH %s: expected 0x%0h got 0x%0h at %0t", what, exp_val, got_val, $realtime);
    mismatch_count++;
  endtask

  // Compare each accepted result beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_views.size() == 0) begin
        report_mismatch("result with nothing pending", 0, 0);
      end else begin
        want = expected_views.pop_front();
        if (active_o !== want.active) report_mismatch("active", want.active, active_o);
        if (pos_x_o !== want.pos_x) report_mismatch("pos_x", want.pos_x, pos_x_o);
        if (pos_y_o !== want.pos_y) report_mismatch("pos_y", want.pos_y, pos_y_o);
        if (cur_scale_o !== want.scale) report_mismatch("cur_scale", want.scale, cur_scale_o);
        if (frame_index_o !== want.frame) report_mismatch("frame_index", want.frame, frame_index_o);
      end
    end
  end

  // Output side: random stalls, or a long hold-off when one is requested
  initial begin
    int stall_left;
    int hold_seen;
    stall_left = 0;
    hold_seen = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_beat(motion_cmd_t m);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i        <= 1'b1;
    command_i         <= m.cmd;
    start_x_i         <= m.sx;
    start_y_i         <= m.sy;
    start_scale_i     <= m.ss;
    end_x_i           <= m.ex;
    end_y_i           <= m.ey;
    end_scale_i       <= m.es;
    tick_count_i      <= m.dur;
    frames_in_loop_i  <= m.frames;
    ticks_per_frame_i <= m.tpf;
    do @(posedge clk_i); while (!in_ready_o);
    expected_views.push_back(advance_sprite(m));
  endtask

  function automatic motion_cmd_t load_cmd(int sx, int sy, int ss, int ex, int ey, int es,
                                           int dur, int frames, int tpf);
    motion_cmd_t m;
    m.cmd = smi_pkg::CMD_LOAD;
    m.sx = smi_pkg::COORD_W'(sx);
    m.sy = smi_pkg::COORD_W'(sy);
    m.ss = smi_pkg::SIZE_W'(ss);
    m.ex = smi_pkg::COORD_W'(ex);
    m.ey = smi_pkg::COORD_W'(ey);
    m.es = smi_pkg::SIZE_W'(es);
    m.dur = smi_pkg::DUR_W'(dur);
    m.frames = smi_pkg::FRAME_W'(frames);
    m.tpf = smi_pkg::FRAME_W'(tpf);
    return m;
  endfunction

  // Tick beats carry random payload, which the block must ignore
  task automatic send_ticks(int count);
    motion_cmd_t m;
    for (int i = 0; i < count; i++) begin
      m = motion_cmd_t'({$urandom(), $urandom(), $urandom(), $urandom()});
      m.cmd = smi_pkg::CMD_TICK;
      send_beat(m);
    end
  endtask

  task automatic test_idle_after_reset();
    send_ticks(2);
  endtask

  task automatic test_extreme_motion();
    // full range in one tick, steps overflowing their width, then the longest run
    send_beat(load_cmd(-2048, 2047, 0, 2047, -2048, 1023, 1, 255, 255));
    send_ticks(2);
    send_beat(load_cmd(2047, -2048, 1023, -2048, 2047, 0, 65535, 1, 1));
    send_ticks(2);
  endtask

  task automatic test_zero_duration();
    send_beat(load_cmd(100, -100, 50, 200, 300, 10, 0, 3, 1));
    send_ticks(2);
  endtask

  task automatic test_frame_wrap();
    send_beat(load_cmd(0, 0, 0, 10, -10, 10, 8, 2, 2));
    send_ticks(5);
    // zero frame count gives 256 frames per loop; no wrap within a short run
    send_beat(load_cmd(-5, 7, 3, 5, -7, 0, 5, 0, 1));
    send_ticks(3);
    // zero frame delay: no advance within a short run
    send_beat(load_cmd(1, 1, 1, 2, 2, 2, 4, 3, 0));
    send_ticks(2);
  endtask

  task automatic test_output_stall();
    send_beat(load_cmd(-300, 400, 20, 600, -200, 700, 20, 4, 3));
    hold_requests++;
    // keep offering ticks while the output is held off
    send_ticks(6);
  endtask

  task automatic test_random_motion(int sender_pct, int receiver_pct, int beat_budget,
                                    bit with_long_run);
    int beats;
    int sel;
    int run_len;
    motion_cmd_t m;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    beats = 0;
    while (beats < beat_budget) begin
      m = motion_cmd_t'({$urandom(), $urandom(), $urandom(), $urandom()});
      m.cmd = smi_pkg::CMD_LOAD;
      sel = $urandom_range(9);
      if (sel <= 5) m.dur = smi_pkg::DUR_W'($urandom_range(1, 24));
      else if (sel <= 7) m.dur = smi_pkg::DUR_W'($urandom_range(25, 300));
      else if (sel == 9) m.dur = '0;
      if ($urandom_range(2) == 0) m.frames = smi_pkg::FRAME_W'($urandom_range(0, 4));
      if ($urandom_range(2) == 0) m.tpf = smi_pkg::FRAME_W'($urandom_range(0, 4));
      if ($urandom_range(7) == 0) begin
        m.sx = $urandom_range(1) ? 12'h800 : 12'h7FF;
        m.ex = ~m.sx;
        m.es = $urandom_range(1) ? '1 : '0;
      end
      run_len = (m.dur < 40) ? int'(m.dur) + $urandom_range(0, 4) : $urandom_range(0, 40);
      if (with_long_run && beats == 0) begin
        // zero delay: frame advances once every 256 ticks
        m.tpf = '0;
        m.dur = smi_pkg::DUR_W'(300);
        run_len = 262;
      end
      // now and then, stray ticks before the next load
      if ($urandom_range(9) == 0) begin
        send_ticks(3);
        beats += 3;
      end
      send_beat(m);
      send_ticks(run_len);
      beats += run_len + 1;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    command_i = smi_pkg::CMD_TICK;
    start_x_i = '0;
    start_y_i = '0;
    start_scale_i = '0;
    end_x_i = '0;
    end_y_i = '0;
    end_scale_i = '0;
    tick_count_i = '0;
    frames_in_loop_i = '0;
    ticks_per_frame_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 26;
    recv_idle_pct = 51;
    test_idle_after_reset();
    test_extreme_motion();
    test_zero_duration();
    test_frame_wrap();
    test_output_stall();
    test_random_motion(26, 51, 370, 1'b1);
    test_random_motion(51, 26, 370, 1'b0);
    test_random_motion(0, 0, 370, 1'b0);

    in_valid_i <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
